[design/cbe_pkg.sv]
package cbe_pkg;

    localparam int CMD_W     = 3;
    localparam int COORD_W   = 14;
    localparam int DIM_W     = 13;
    localparam int PIX_W     = 24;
    localparam int SRC_PIX_W = 32;
    localparam int IDX_W     = 24;

    localparam int MAX_DIM_DEFAULT     = 4096;
    localparam int CANVAS_WIDTH_RESET  = 640;
    localparam int CANVAS_HEIGHT_RESET = 480;

    localparam int S_TDATA_W = 192;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 104;

    localparam int M_WEN_BIT   = 24;
    localparam int M_EMPTY_BIT = 97;
    localparam int M_BUSY_BIT  = 98;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COPY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_KEYED  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHADOW = 3'd4;

    localparam logic CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic CFG_CANVAS_HEIGHT = 1'b1;

    localparam logic [7:0] ALPHA_KEY_MIN     = 8'd192;
    localparam logic [7:0] SHADOW_BLUE_LIMIT = 8'd128;
    localparam logic [PIX_W-1:0] HALF_MASK   = 24'h7f7f7f;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
        logic signed [COORD_W-1:0] dst_x;
        logic signed [COORD_W-1:0] dst_y;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic [DIM_W-1:0]          image_width;
        logic [DIM_W-1:0]          image_height;
        logic [PIX_W-1:0]          fill_rgb;
        logic [SRC_PIX_W-1:0]      source_pixel;
        logic [PIX_W-1:0]          dest_pixel;
    } item_t;

    typedef struct packed {
        logic             empty;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [IDX_W-1:0] dst_cursor;
        logic [IDX_W-1:0] src_cursor;
        logic [DIM_W-1:0] src_stride;
    } setup_t;

    typedef struct packed {
        logic [IDX_W-1:0] write_index;
        logic             write_enable;
        logic [PIX_W-1:0] write_pixel;
        logic [IDX_W-1:0] next_src_index;
        logic [IDX_W-1:0] next_dst_index;
        logic             last;
        logic             empty_res;
        logic             busy_res;
    } result_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W:0] lim);
        return ({1'b0, v} > lim) ? lim[DIM_W-1:0] : v;
    endfunction

endpackage

[design/cbe_in_stage.sv]
module cbe_in_stage
    import cbe_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  take,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready = !valid_reg || take;
    assign valid   = valid_reg;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

[design/cbe_clip.sv]
module cbe_clip
    import cbe_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  item_t            item,
    input  logic [DIM_W-1:0] canvas_width,
    input  logic [DIM_W-1:0] canvas_height,
    output setup_t           setup
);

    localparam int CW = 18;

    typedef struct packed {
        logic signed [CW-1:0] len;
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] d;
    } axis_t;

    function automatic axis_t clip_axis(input logic signed [CW-1:0] s_in,
                                        input logic signed [CW-1:0] d_in,
                                        input logic signed [CW-1:0] len_in,
                                        input logic signed [CW-1:0] dlim,
                                        input logic signed [CW-1:0] slim,
                                        input logic use_src);
        axis_t a;
        a.s   = s_in;
        a.d   = d_in;
        a.len = len_in;
        if (a.d < 0) begin
            a.len = a.len + a.d;
            a.s   = a.s - a.d;
            a.d   = '0;
        end
        if (use_src && a.s < 0) begin
            a.len = a.len + a.s;
            a.d   = a.d - a.s;
            a.s   = '0;
        end
        if (a.d + a.len > dlim) begin
            a.len = dlim - a.d;
        end
        if (use_src && a.s + a.len > slim) begin
            a.len = slim - a.s;
        end
        return a;
    endfunction

    function automatic logic signed [CW-1:0] sx(input logic signed [COORD_W-1:0] v);
        return {{(CW-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    logic                 use_src;
    logic                 shadow;
    logic [DIM_W-1:0]     iw;
    logic [DIM_W-1:0]     ih;
    logic signed [CW-1:0] xs, ys, w, h;
    axis_t                ax, ay;
    logic                 w_ok, h_ok;
    logic [2*COORD_W-1:0] dst_row, src_row;

    assign use_src = (item.cmd != CMD_FILL);
    assign shadow  = (item.cmd == CMD_SHADOW);
    assign iw      = sat_dim(item.image_width, (DIM_W+1)'(MAX_DIM));
    assign ih      = sat_dim(item.image_height, (DIM_W+1)'(MAX_DIM));
    assign xs      = shadow ? '0 : sx(item.src_x);
    assign ys      = shadow ? '0 : sx(item.src_y);
    assign w       = shadow ? CW'(iw) : sx(item.rect_width);
    assign h       = shadow ? CW'(ih) : sx(item.rect_height);

    assign ax = clip_axis(xs, sx(item.dst_x), w, CW'(canvas_width), CW'(iw), use_src);
    assign ay = clip_axis(ys, sx(item.dst_y), h, CW'(canvas_height), CW'(ih), use_src);

    assign w_ok = !ax.len[CW-1] && (ax.len != '0);
    assign h_ok = !ay.len[CW-1] && (ay.len != '0);

    assign dst_row = ay.d[COORD_W-1:0] * {{(COORD_W-DIM_W){1'b0}}, canvas_width};
    assign src_row = ay.s[COORD_W-1:0] * {{(COORD_W-DIM_W){1'b0}}, iw};

    always_comb begin
        setup.empty      = !(w_ok && h_ok);
        setup.width      = ax.len[DIM_W-1:0];
        setup.height     = ay.len[DIM_W-1:0];
        setup.dst_cursor = IDX_W'(ax.d) + dst_row[IDX_W-1:0];
        setup.src_cursor = use_src ? IDX_W'(ax.s) + src_row[IDX_W-1:0] : '0;
        setup.src_stride = use_src ? iw : '0;
    end

endmodule

[design/cbe_core.sv]
module cbe_core
    import cbe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  item_t            item,
    input  setup_t           setup,
    input  logic [DIM_W-1:0] canvas_width,
    output logic             take,
    output logic             m_valid,
    input  logic             m_ready,
    output result_t          result
);

    logic [CMD_W-1:0] op_mode_reg, op_mode_next;
    logic             busy_reg, busy_next;
    logic [DIM_W-1:0] column_count_reg, column_count_next;
    logic [DIM_W-1:0] row_count_reg, row_count_next;
    logic [DIM_W-1:0] clip_width_reg, clip_width_next;
    logic [IDX_W-1:0] dst_cursor_reg, dst_cursor_next;
    logic [IDX_W-1:0] src_cursor_reg, src_cursor_next;
    logic [DIM_W-1:0] src_stride_reg, src_stride_next;
    logic [PIX_W-1:0] saved_fill_reg, saved_fill_next;
    logic             m_valid_reg;
    result_t          result_reg, result_next;
    logic [DIM_W-1:0] rows_left;

    assign take    = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    always_comb begin
        op_mode_next      = op_mode_reg;
        busy_next         = busy_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        clip_width_next   = clip_width_reg;
        dst_cursor_next   = dst_cursor_reg;
        src_cursor_next   = src_cursor_reg;
        src_stride_next   = src_stride_reg;
        saved_fill_next   = saved_fill_reg;
        result_next       = '0;
        rows_left         = row_count_reg - DIM_W'(1);

        case (item.cmd)
            CMD_FILL, CMD_COPY, CMD_KEYED, CMD_SHADOW: begin
                if (setup.empty) begin
                    busy_next             = 1'b0;
                    op_mode_next          = CMD_TICK;
                    result_next.empty_res = 1'b1;
                end else begin
                    op_mode_next      = item.cmd;
                    busy_next         = 1'b1;
                    clip_width_next   = setup.width;
                    column_count_next = setup.width;
                    row_count_next    = setup.height;
                    saved_fill_next   = item.fill_rgb;
                    dst_cursor_next   = setup.dst_cursor;
                    src_cursor_next   = setup.src_cursor;
                    src_stride_next   = setup.src_stride;
                end
            end
            CMD_TICK: begin
                if (busy_reg) begin
                    result_next.write_index = dst_cursor_reg;
                    case (op_mode_reg)
                        CMD_FILL: begin
                            result_next.write_enable = 1'b1;
                            result_next.write_pixel  = saved_fill_reg;
                        end
                        CMD_COPY: begin
                            result_next.write_enable = 1'b1;
                            result_next.write_pixel  = item.source_pixel[PIX_W-1:0];
                        end
                        CMD_KEYED: begin
                            if (item.source_pixel[SRC_PIX_W-1:PIX_W] >= ALPHA_KEY_MIN) begin
                                result_next.write_enable = 1'b1;
                                result_next.write_pixel  = item.source_pixel[PIX_W-1:0];
                            end
                        end
                        CMD_SHADOW: begin
                            if (item.source_pixel[7:0] < SHADOW_BLUE_LIMIT) begin
                                result_next.write_enable = 1'b1;
                                result_next.write_pixel  = (item.dest_pixel >> 1) & HALF_MASK;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (column_count_reg > DIM_W'(1)) begin
                        column_count_next = column_count_reg - DIM_W'(1);
                        dst_cursor_next   = dst_cursor_reg + IDX_W'(1);
                        if (op_mode_reg != CMD_FILL) begin
                            src_cursor_next = src_cursor_reg + IDX_W'(1);
                        end
                    end else begin
                        row_count_next = rows_left;
                        if (rows_left == '0) begin
                            busy_next        = 1'b0;
                            result_next.last = 1'b1;
                        end else begin
                            column_count_next = clip_width_reg;
                            dst_cursor_next   = dst_cursor_reg + IDX_W'(canvas_width)
                                                - IDX_W'(clip_width_reg) + IDX_W'(1);
                            if (op_mode_reg != CMD_FILL) begin
                                src_cursor_next = src_cursor_reg + IDX_W'(src_stride_reg)
                                                  - IDX_W'(clip_width_reg) + IDX_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        result_next.busy_res       = busy_next;
        result_next.next_src_index = busy_next ? src_cursor_next : '0;
        result_next.next_dst_index = busy_next ? dst_cursor_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg      <= CMD_TICK;
            busy_reg         <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            clip_width_reg   <= '0;
            dst_cursor_reg   <= '0;
            src_cursor_reg   <= '0;
            src_stride_reg   <= '0;
            saved_fill_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= in_valid;
            end
            if (take && in_valid) begin
                op_mode_reg      <= op_mode_next;
                busy_reg         <= busy_next;
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                clip_width_reg   <= clip_width_next;
                dst_cursor_reg   <= dst_cursor_next;
                src_cursor_reg   <= src_cursor_next;
                src_stride_reg   <= src_stride_next;
                saved_fill_reg   <= saved_fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_valid) begin
            result_reg <= result_next;
        end
    end

endmodule

[design/clipped_rect_blit_engine.sv]
// A transaction taken on s_ is held in the input register and its result in the result
// register, from which it is offered on m_. Throughput: one transaction per cycle while m_
// is not stalled, start or tick alike; the region walk state is updated by the single
// compute stage between input and result registers. Stalls on m_ hold the result
// register and back-pressure s_ through the input register. Reset (aresetn low,
// synchronous) empties both registers, goes idle and loads canvas size 640 x 480.
module clipped_rect_blit_engine
    import cbe_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // src_x, src_y, dst_x, dst_y, rect_width, rect_height, image_width,
    // image_height, fill_rgb, source_pixel, dest_pixel, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // write_index, write_enable, write_pixel, next_src_index, next_dst_index,
    // empty_res, busy_res, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata
);

    logic [DIM_W-1:0] canvas_width_reg;
    logic [DIM_W-1:0] canvas_height_reg;
    item_t            s_item;
    item_t            item;
    logic             item_valid;
    logic             take;
    setup_t           setup;
    result_t          result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= DIM_W'(CANVAS_WIDTH_RESET);
            canvas_height_reg <= DIM_W'(CANVAS_HEIGHT_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:
                    canvas_width_reg <= sat_dim(cfg_wdata, (DIM_W+1)'(MAX_DIM));
                CFG_CANVAS_HEIGHT:
                    canvas_height_reg <= sat_dim(cfg_wdata, (DIM_W+1)'(MAX_DIM));
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s_item.cmd          = s_tuser;
        s_item.src_x        = s_tdata[13:0];
        s_item.src_y        = s_tdata[27:14];
        s_item.dst_x        = s_tdata[41:28];
        s_item.dst_y        = s_tdata[55:42];
        s_item.rect_width   = s_tdata[69:56];
        s_item.rect_height  = s_tdata[83:70];
        s_item.image_width  = s_tdata[96:84];
        s_item.image_height = s_tdata[109:97];
        s_item.fill_rgb     = s_tdata[133:110];
        s_item.source_pixel = s_tdata[165:134];
        s_item.dest_pixel   = s_tdata[189:166];
    end

    cbe_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .take    (take),
        .valid   (item_valid),
        .item    (item)
    );

    cbe_clip #(
        .MAX_DIM (MAX_DIM)
    ) u_clip (
        .item          (item),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .setup         (setup)
    );

    cbe_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (item_valid),
        .item         (item),
        .setup        (setup),
        .canvas_width (canvas_width_reg),
        .take         (take),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .result       (result)
    );

    assign m_tdata = {5'b0, result.busy_res, result.empty_res, result.next_dst_index,
                      result.next_src_index, result.write_pixel, result.write_enable,
                      result.write_index};
    assign m_tlast = result.last;

endmodule

[design/cbe_checker.sv]
module cbe_checker
    import cbe_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result transaction changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[M_BUSY_BIT] && !m_tdata[M_EMPTY_BIT])
        else $error("last transaction still busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_EMPTY_BIT] |-> !m_tdata[M_BUSY_BIT] && !m_tdata[M_WEN_BIT]
                                           && (m_tdata[96:49] == '0))
        else $error("empty clip reported with live region");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_WEN_BIT] |-> (m_tdata[48:25] == '0))
        else $error("pixel data without write enable");

endmodule

bind clipped_rect_blit_engine cbe_checker u_cbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
